// ===== src/tdcp_pkg.sv =====
// Package for the tagged decimal command parser: constants, types and codes.
package tdcp_pkg;

  localparam int unsigned MaxTextLen = 64;
  localparam int unsigned CountW     = 7;

  localparam logic [7:0] ByteCr    = 8'h0d;
  localparam logic [7:0] ByteLf    = 8'h0a;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteNine  = 8'h39;
  localparam logic [7:0] BytePlus  = 8'h2b;
  localparam logic [7:0] ByteMinus = 8'h2d;
  localparam logic [7:0] NoTag     = 8'h00;

  localparam logic [7:0] TagPitch    = 8'h70; // p
  localparam logic [7:0] TagRoll     = 8'h72; // r
  localparam logic [7:0] TagThrottle = 8'h67; // g
  localparam logic [7:0] TagHeight   = 8'h68; // h
  localparam logic [7:0] TagYaw      = 8'h79; // y
  localparam logic [7:0] TagKey      = 8'h6b; // k
  localparam logic [7:0] TagSilent   = 8'h73; // s

  typedef enum logic [2:0] {
    TGT_ROLL     = 3'd0,
    TGT_PITCH    = 3'd1,
    TGT_THROTTLE = 3'd2,
    TGT_YAW      = 3'd3,
    TGT_HEIGHT   = 3'd4,
    TGT_KEY      = 3'd5
  } target_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0]        tag;
    logic              cr_seen;
    logic [CountW-1:0] text_count;
    phase_e            phase;
    logic              negative;
    logic [15:0]       acc;
  } frame_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [15:0] value;
    logic        command_flag;
  } result_t;

  localparam frame_t FrameReset = '{
    tag:        NoTag,
    cr_seen:    1'b0,
    text_count: '0,
    phase:      PH_LEAD,
    negative:   1'b0,
    acc:        16'd0
  };

endpackage

// ===== src/tdcp_if.sv =====
// Beat channel interfaces: received byte stream and parsed command results.
interface tdcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tdcp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [15:0] value;
  logic        command_flag;

  modport source (output valid, output target, output value, output command_flag,
                  input ready);
  modport sink (input valid, input target, input value, input command_flag,
                output ready);
endinterface

// ===== src/tagged_decimal_command_parser_unit.sv =====
// Top level of the tagged decimal command parser.
//
//  channel | dir | payload                          | beat
//  rx_i    | in  | rx_byte[7:0]                     | one received byte
//  res_o   | out | target[2:0] value[15:0] cmd flag | one parsed command
//
// One byte per cycle: frame state is updated in the accepting cycle and a
// result lands in the output register in the cycle after its LF beat.
// Reset clears the frame state and the output valid.
// rx_i stalls only while a result is held and res_o is not ready.
module tagged_decimal_command_parser_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  tdcp_rx_if.sink           rx_i,
  tdcp_res_if.source        res_o
);

  tdcp_pkg::frame_t  frame_q, frame_d;
  tdcp_pkg::result_t res_d, res_q;
  logic              emit;
  logic              out_valid_q;
  logic              rx_beat;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_beat    = rx_i.valid && rx_i.ready;

  tdcp_step u_step (
    .cur_i  (frame_q),
    .byte_i (rx_i.rx_byte),
    .nxt_o  (frame_d),
    .emit_o (emit),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= tdcp_pkg::FrameReset;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_beat) begin
        frame_q <= frame_d;
      end
      if (rx_beat && emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_beat && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.target       = res_q.target;
  assign res_o.value        = res_q.value;
  assign res_o.command_flag = res_q.command_flag;

endmodule

// ===== src/tdcp_step.sv =====
// Next-state logic of the frame parser for one received byte.
module tdcp_step (
  input  tdcp_pkg::frame_t  cur_i,
  input  logic [7:0]        byte_i,
  output tdcp_pkg::frame_t  nxt_o,
  output logic              emit_o,
  output tdcp_pkg::result_t res_o
);

  logic                        is_digit;
  logic                        is_space;
  logic                        tag_known;
  logic [15:0]                 acc_next;
  logic [tdcp_pkg::CountW-1:0] count_inc;

  assign is_digit = (byte_i >= tdcp_pkg::ByteZero) && (byte_i <= tdcp_pkg::ByteNine);
  assign is_space = (byte_i == tdcp_pkg::ByteSpace) ||
                    ((byte_i >= tdcp_pkg::ByteTab) && (byte_i <= tdcp_pkg::ByteCr));
  assign tag_known = (cur_i.tag == tdcp_pkg::TagPitch) || (cur_i.tag == tdcp_pkg::TagRoll) ||
                     (cur_i.tag == tdcp_pkg::TagThrottle) ||
                     (cur_i.tag == tdcp_pkg::TagHeight) ||
                     (cur_i.tag == tdcp_pkg::TagYaw) || (cur_i.tag == tdcp_pkg::TagKey) ||
                     (cur_i.tag == tdcp_pkg::TagSilent);
  // acc * 10 + digit, wrapped to 16 bits
  assign acc_next = {cur_i.acc[12:0], 3'b000} + {cur_i.acc[14:0], 1'b0} +
                    {12'd0, byte_i[3:0] - tdcp_pkg::ByteZero[3:0]};
  assign count_inc = cur_i.text_count + tdcp_pkg::CountW'(1);

  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    res_o.target       = tdcp_pkg::TGT_ROLL;
    res_o.command_flag = 1'b0;
    res_o.value        = cur_i.negative ? (16'd0 - cur_i.acc) : cur_i.acc;
    if (cur_i.cr_seen) begin
      nxt_o = tdcp_pkg::FrameReset;
      if (byte_i == tdcp_pkg::ByteLf) begin
        emit_o = 1'b1;
        case (cur_i.tag)
          tdcp_pkg::TagPitch: begin
            res_o.target       = tdcp_pkg::TGT_PITCH;
            res_o.command_flag = 1'b1;
          end
          tdcp_pkg::TagRoll: begin
            res_o.target       = tdcp_pkg::TGT_ROLL;
            res_o.command_flag = 1'b1;
          end
          tdcp_pkg::TagThrottle: res_o.target = tdcp_pkg::TGT_THROTTLE;
          tdcp_pkg::TagHeight:   res_o.target = tdcp_pkg::TGT_HEIGHT;
          tdcp_pkg::TagYaw:      res_o.target = tdcp_pkg::TGT_YAW;
          tdcp_pkg::TagKey:      res_o.target = tdcp_pkg::TGT_KEY;
          default:               emit_o = 1'b0;
        endcase
      end
    end else if (byte_i == tdcp_pkg::ByteCr) begin
      nxt_o.cr_seen = 1'b1;
    end else if (cur_i.tag == tdcp_pkg::NoTag) begin
      nxt_o.tag = byte_i;
    end else if (!tag_known) begin
      nxt_o.tag = tdcp_pkg::NoTag;
    end else begin
      if (cur_i.phase != tdcp_pkg::PH_DONE) begin
        if (is_digit) begin
          nxt_o.acc   = acc_next;
          nxt_o.phase = tdcp_pkg::PH_DIGITS;
        end else if ((cur_i.phase == tdcp_pkg::PH_LEAD) && is_space) begin
          nxt_o.phase = tdcp_pkg::PH_LEAD;
        end else if ((cur_i.phase == tdcp_pkg::PH_LEAD) &&
                     ((byte_i == tdcp_pkg::BytePlus) || (byte_i == tdcp_pkg::ByteMinus))) begin
          nxt_o.negative = (byte_i == tdcp_pkg::ByteMinus);
          nxt_o.phase    = tdcp_pkg::PH_SIGN;
        end else begin
          nxt_o.phase = tdcp_pkg::PH_DONE;
        end
      end
      nxt_o.text_count = count_inc;
      if (count_inc >= tdcp_pkg::CountW'(tdcp_pkg::MaxTextLen)) begin
        nxt_o = tdcp_pkg::FrameReset;
      end
    end
  end

endmodule

// ===== tb/tagged_decimal_command_parser_unit_test.sv =====
// Self-checking testbench for the tagged decimal command parser: directed, random and stall tests.
module tagged_decimal_command_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] KnownTags [7] = '{tdcp_pkg::TagPitch, tdcp_pkg::TagRoll,
                                           tdcp_pkg::TagThrottle, tdcp_pkg::TagHeight,
                                           tdcp_pkg::TagYaw, tdcp_pkg::TagKey,
                                           tdcp_pkg::TagSilent};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tdcp_rx_if  rx ();
  tdcp_res_if res ();

  tagged_decimal_command_parser_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res)
  );

  tdcp_pkg::frame_t  frm;
  tdcp_pkg::result_t cmd_queue[$];
  int                errors = 0;
  int                bytes_sent = 0;
  int                results_seen = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_left = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    res.ready  = 1'b0;
    frm        = tdcp_pkg::FrameReset;
  end

  function automatic bit is_known_tag(input logic [7:0] t);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (t == KnownTags[k]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Next state of the frame for one accepted byte; returns 1 when a command is due.
  function automatic bit decode_rx_byte(input logic [7:0] b, output tdcp_pkg::result_t cmd);
    bit emit;
    bit is_digit;
    bit is_space;
    emit = 1'b0;
    cmd = '0;
    is_digit = (b >= tdcp_pkg::ByteZero) && (b <= tdcp_pkg::ByteNine);
    is_space = (b == tdcp_pkg::ByteSpace) ||
               ((b >= tdcp_pkg::ByteTab) && (b <= tdcp_pkg::ByteCr));
    if (frm.cr_seen) begin
      if (b == tdcp_pkg::ByteLf) begin
        emit = 1'b1;
        case (frm.tag)
          tdcp_pkg::TagPitch: begin
            cmd.target = tdcp_pkg::TGT_PITCH;
            cmd.command_flag = 1'b1;
          end
          tdcp_pkg::TagRoll: begin
            cmd.target = tdcp_pkg::TGT_ROLL;
            cmd.command_flag = 1'b1;
          end
          tdcp_pkg::TagThrottle: cmd.target = tdcp_pkg::TGT_THROTTLE;
          tdcp_pkg::TagHeight:   cmd.target = tdcp_pkg::TGT_HEIGHT;
          tdcp_pkg::TagYaw:      cmd.target = tdcp_pkg::TGT_YAW;
          tdcp_pkg::TagKey:      cmd.target = tdcp_pkg::TGT_KEY;
          default:               emit = 1'b0;
        endcase
        cmd.value = frm.negative ? 16'(~frm.acc + 16'd1) : frm.acc;
      end
      frm = tdcp_pkg::FrameReset;
    end else if (b == tdcp_pkg::ByteCr) begin
      frm.cr_seen = 1'b1;
    end else if (frm.tag == tdcp_pkg::NoTag) begin
      frm.tag = b;
    end else if (!is_known_tag(frm.tag)) begin
      frm.tag = tdcp_pkg::NoTag;
    end else begin
      if (frm.phase != tdcp_pkg::PH_DONE) begin
        if (is_digit) begin
          frm.acc = 16'(frm.acc * 10 + (b - tdcp_pkg::ByteZero));
          frm.phase = tdcp_pkg::PH_DIGITS;
        end else if (frm.phase == tdcp_pkg::PH_LEAD && is_space) begin
        end else if (frm.phase == tdcp_pkg::PH_LEAD &&
                     (b == tdcp_pkg::BytePlus || b == tdcp_pkg::ByteMinus)) begin
          frm.negative = (b == tdcp_pkg::ByteMinus);
          frm.phase = tdcp_pkg::PH_SIGN;
        end else begin
          frm.phase = tdcp_pkg::PH_DONE;
        end
      end
      frm.text_count = frm.text_count + 1'b1;
      if (frm.text_count >= tdcp_pkg::MaxTextLen) frm = tdcp_pkg::FrameReset;
    end
    return emit;
  endfunction

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on each accepted byte, check each accepted command.
  always @(posedge clk_i) begin
    tdcp_pkg::result_t want;
    tdcp_pkg::result_t pred;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        results_seen++;
        if (cmd_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected command: expected none, got target %0d value %0d flag %0b",
                   $time, res.target, res.value, res.command_flag);
        end else begin
          want = cmd_queue.pop_front();
          if (res.target !== want.target) begin
            errors++;
            $display("%0t: target mismatch: expected %0d, got %0d",
                     $time, want.target, res.target);
          end
          if (res.value !== want.value) begin
            errors++;
            $display("%0t: value mismatch: expected %0d, got %0d",
                     $time, want.value, res.value);
          end
          if (res.command_flag !== want.command_flag) begin
            errors++;
            $display("%0t: command flag mismatch: expected %0b, got %0b",
                     $time, want.command_flag, res.command_flag);
          end
        end
      end
      if (rx.valid && rx.ready) begin
        if (decode_rx_byte(rx.rx_byte, pred)) cmd_queue.push_back(pred);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!(rx.valid && rx.ready));
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] tag, input string text);
    send_byte(tag);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(tdcp_pkg::ByteCr);
    send_byte(tdcp_pkg::ByteLf);
  endtask

  task automatic send_random_frame();
    logic [7:0] beats[$];
    int kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) beats.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(9) == 0) beats.push_back(8'($urandom_range(255)));
      else beats.push_back(KnownTags[$urandom_range(6)]);
      if (kind < 12) begin
        // long text, may run into the length limit
        repeat ($urandom_range(58, 70))
          beats.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                   : 8'(tdcp_pkg::ByteZero + $urandom_range(9)));
      end else begin
        repeat ($urandom_range(0, 2))
          beats.push_back(($urandom_range(1) == 0) ? tdcp_pkg::ByteSpace
                                                   : 8'(tdcp_pkg::ByteTab + $urandom_range(3)));
        case ($urandom_range(3))
          0: beats.push_back(tdcp_pkg::BytePlus);
          1: beats.push_back(tdcp_pkg::ByteMinus);
          default: begin end
        endcase
        repeat ($urandom_range(0, 7))
          beats.push_back(8'(tdcp_pkg::ByteZero + $urandom_range(9)));
        if ($urandom_range(9) == 0) begin
          beats.push_back(8'($urandom_range(255)));
          repeat ($urandom_range(0, 2))
            beats.push_back(8'(tdcp_pkg::ByteZero + $urandom_range(9)));
        end
      end
      beats.push_back(tdcp_pkg::ByteCr);
      beats.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : tdcp_pkg::ByteLf);
    end
    foreach (beats[i]) send_byte(beats[i]);
  endtask

  // Sender pauses until every predicted command has come out.
  task automatic wait_idle();
    rx.valid <= 1'b0;
    @(posedge clk_i);
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_frame(tdcp_pkg::TagPitch, "-1");
    send_frame(tdcp_pkg::TagRoll, " 70000");
    send_frame(tdcp_pkg::TagThrottle, "+65535");
    send_frame(tdcp_pkg::TagHeight, "");
    send_frame(tdcp_pkg::TagYaw, "\t-x5");
    send_frame(tdcp_pkg::TagKey, "12a3");
    send_frame(tdcp_pkg::TagSilent, "7");
    send_byte(8'hff);
    send_byte(tdcp_pkg::ByteZero);
    send_frame(tdcp_pkg::TagKey, "9");
    send_byte(tdcp_pkg::NoTag);
    send_byte(tdcp_pkg::TagHeight);
    send_byte(tdcp_pkg::ByteCr);
    send_byte(tdcp_pkg::NoTag);
    send_byte(tdcp_pkg::ByteCr);
    send_byte(tdcp_pkg::ByteLf);
    wait_idle();
  endtask

  task automatic test_random(input int s_pct, input int r_pct, input int n_bytes);
    int stop_at;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 200;
    repeat (15) send_frame(tdcp_pkg::TagThrottle, "42");
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(23, 45, 590);
    test_random(45, 23, 590);
    test_random(0, 0, 590);
    $display("Run covered %0d received bytes and %0d parsed commands with %0d mismatches.",
             bytes_sent, results_seen, errors);
    $display("Directed frames, long-frame discards, stalls both ways and a long output hold.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d commands outstanding", cmd_queue.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tdcp_pkg.sv
src/tdcp_if.sv
src/tdcp_step.sv
src/tagged_decimal_command_parser_unit.sv
tb/tagged_decimal_command_parser_unit_test.sv
